// File: hdl/kchp_pkg.sv
// Shared types, constants and the PWM setting table for the key click/hold block.
// No dependencies; used by kchp_scan, kchp_pwm and key_click_hold_pwm_select.
package kchp_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned KeyW   = 3;

  localparam logic [KeyW-1:0]   KeysReleased = 3'b111;
  localparam logic [CodeW-1:0]  HoldBit      = 8'h80;
  localparam logic [CountW-1:0] CountTop     = 16'hFFFF;
  localparam logic [CountW-1:0] ThreshReset  = 16'd12;

  localparam logic [1:0] PreNormal = 2'd2;
  localparam logic [1:0] PreTop    = 2'd1;

  typedef struct packed {
    logic       pwm_on;
    logic [1:0] prescale_select;
    logic [7:0] period_value;
    logic [7:0] duty_value;
  } pwm_t;

  // Multiplier m = 2^(key-1), times 8 on a long press; period = 240/m - 1,
  // or 29 with the top prescale when m is 32; duty = (period + 1) / 2.
  function automatic pwm_t pwm_lookup(input logic [CodeW-1:0] code);
    pwm_t r;
    r = '0;
    if (code != '0) begin
      r.pwm_on = 1'b1;
      r.prescale_select = PreNormal;
      case ({code[7], code[2:0]})
        4'b0010: begin r.period_value = 8'd119; r.duty_value = 8'd60; end
        4'b0011: begin r.period_value = 8'd59;  r.duty_value = 8'd30; end
        4'b1001: begin r.period_value = 8'd29;  r.duty_value = 8'd15; end
        4'b1010: begin r.period_value = 8'd14;  r.duty_value = 8'd7;  end
        4'b1011: begin
          r.prescale_select = PreTop;
          r.period_value = 8'd29;
          r.duty_value = 8'd15;
        end
        default: begin
          if (code[7]) begin
            r.period_value = 8'd29;
            r.duty_value = 8'd15;
          end else begin
            r.period_value = 8'd239;
            r.duty_value = 8'd120;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

// File: hdl/kchp_scan.sv
// Key scan: click/hold flags, saturating hold counter and event code per tick.
// Depends on kchp_pkg.
module kchp_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic [kchp_pkg::KeyW-1:0]   keys_n_i,
  input  logic [kchp_pkg::CountW-1:0] threshold_i,
  output logic [kchp_pkg::CodeW-1:0]  event_code_o
);
  import kchp_pkg::*;

  logic              click_q, click_d;
  logic              hold_q, hold_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CodeW-1:0]  ev;
  logic              done;

  always_comb begin
    click_d = click_q;
    hold_d  = hold_q;
    count_d = count_q;
    ev      = '0;
    done    = 1'b0;
    if (keys_n_i == KeysReleased) begin
      click_d = 1'b0;
      hold_d  = 1'b0;
      count_d = '0;
    end else begin
      for (int k = 0; k < KeyW; k++) begin
        if (!done && !keys_n_i[k]) begin
          if (!click_d) begin
            click_d = 1'b1;
            ev      = CodeW'(k + 1);
            done    = 1'b1;
          end else if (!hold_d && count_d > threshold_i) begin
            hold_d = 1'b1;
            ev     = HoldBit | CodeW'(k + 1);
            done   = 1'b1;
          end else if (count_d != CountTop) begin
            count_d = count_d + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_q <= 1'b0;
      hold_q  <= 1'b0;
      count_q <= '0;
    end else if (take_i) begin
      click_q <= click_d;
      hold_q  <= hold_d;
      count_q <= count_d;
    end
  end

  assign event_code_o = ev;

endmodule

// File: hdl/kchp_pwm.sv
// Latched code register and PWM setting derived from the updated code.
// Depends on kchp_pkg.
module kchp_pwm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [kchp_pkg::CodeW-1:0] event_code_i,
  output logic [kchp_pkg::CodeW-1:0] latched_d_o,
  output kchp_pkg::pwm_t             pwm_d_o
);
  import kchp_pkg::*;

  logic [CodeW-1:0] latched_q, latched_d;

  assign latched_d = (event_code_i != '0) ? event_code_i : latched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= '0;
    end else if (take_i) begin
      latched_q <= latched_d;
    end
  end

  assign latched_d_o = latched_d;
  assign pwm_d_o     = pwm_lookup(latched_d);

endmodule

// File: hdl/key_click_hold_pwm_select.sv
// Top level of the key click/hold detector with PWM setting selection.
// Depends on kchp_pkg, kchp_scan and kchp_pwm.
//
// One request is one timer tick carrying three active-low key levels; each
// gives exactly one result in the cycle after acceptance. A request can be taken
// every cycle: the scan and the PWM table are combinational logic feeding one
// result register, and input stall is raised only while that register holds a
// result that the downstream side stalls. The hold threshold (reset 12) is
// written through the config port, which is always ready.
module key_click_hold_pwm_select (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kchp_pkg::KeyW-1:0]   keys_n_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kchp_pkg::CountW-1:0] cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  event_code_o,
  output logic [7:0]                  latched_code_o,
  output logic                        pwm_on_o,
  output logic [1:0]                  prescale_select_o,
  output logic [7:0]                  period_value_o,
  output logic [7:0]                  duty_value_o
);
  import kchp_pkg::*;

  logic              take;
  logic [CountW-1:0] thresh_q;
  logic [CodeW-1:0]  ev;
  logic [CodeW-1:0]  latched_d;
  pwm_t              pwm_d;
  logic              out_valid_q;
  logic [CodeW-1:0]  ev_q, latched_q;
  pwm_t              pwm_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign take        = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  kchp_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .keys_n_i     (keys_n_i),
    .threshold_i  (thresh_q),
    .event_code_o (ev)
  );

  kchp_pwm u_pwm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .event_code_i (ev),
    .latched_d_o  (latched_d),
    .pwm_d_o      (pwm_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q      <= ev;
      latched_q <= latched_d;
      pwm_q     <= pwm_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_code_o      = ev_q;
  assign latched_code_o    = latched_q;
  assign pwm_on_o          = pwm_q.pwm_on;
  assign prescale_select_o = pwm_q.prescale_select;
  assign period_value_o    = pwm_q.period_value;
  assign duty_value_o      = pwm_q.duty_value;

endmodule
